// ===== rtl/imfsc_pkg.sv =====
// ----------------------------------------------------------------------------
// imfsc_pkg
// Types and signature constants for the instant-messaging flow classifier.
// ----------------------------------------------------------------------------
package imfsc_pkg;

  typedef enum logic [1:0] {
    VERDICT_UNDECIDED = 2'd0,
    VERDICT_MATCH     = 2'd1,
    VERDICT_EXCLUDED  = 2'd2
  } verdict_t;

  typedef logic [3:0] stage_t;

  localparam int     HEAD_BYTES   = 24;
  localparam int     HEAD_BITS    = 8 * HEAD_BYTES;

  localparam stage_t STAGE_ZERO   = 4'd0;
  localparam stage_t STAGE_LIMIT  = 4'd3;
  localparam stage_t STAGE_ARMED  = 4'd4;
  localparam stage_t STAGE_CONF   = 4'd5;
  localparam stage_t STAGE_BROKEN = 4'd6;
  localparam stage_t STAGE_MAX    = 4'd15;

  // fixed header signature
  localparam logic [7:0] HDR_B0     = 8'h88;
  localparam logic [7:0] HDR_B1     = 8'h06;
  localparam logic [7:0] HDR_B16    = 8'h01;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_ONE   = 8'h01;

  // handshake arm and confirm bytes
  localparam logic [7:0] ARM_B0     = 8'h37;
  localparam logic [7:0] ARM_B2     = 8'h0c;
  localparam logic [3:0] CONF_NIB   = 4'h2;

  localparam logic [15:0] LEN_HDR   = 16'd24;
  localparam logic [15:0] LEN_CORE  = 16'd20;

  // markers, first byte in the low bits
  localparam int          CORE_LEN  = 10;
  localparam int          HAND_LEN  = 5;
  localparam logic [8*CORE_LEN-1:0] MARKER_CORE = 80'h40_65_72_6f_43_6d_63_54_07_40;
  localparam logic [8*HAND_LEN-1:0] MARKER_HAND = 40'h40_78_77_02_40;
  localparam int          CORE_OFF_A = 7;
  localparam int          CORE_OFF_B = 9;
  localparam int          HAND_OFF   = 7;

endpackage

// ===== rtl/im_flow_signature_classifier.sv =====
// ----------------------------------------------------------------------------
// im_flow_signature_classifier
// Per-packet classifier with a flow-indexed stage table held in one memory.
// ----------------------------------------------------------------------------
// pipeline: two register stages, stage one and the output register; an
//   accepted input beat passes through both and can wait in either on a stall
// throughput: one beat per cycle unless out_ready stalls the output, set by
//   one stage-memory read-modify-write per packet with forwarding of the previous write
// reset: every stage memory entry is cleared to zero after reset, in_ready
//   low throughout the clearing pass
module im_flow_signature_classifier #(
  parameter int FLOW_COUNT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  flow_index,
  input  logic        new_flow,
  input  logic        is_tcp,
  input  logic [15:0] pkt_len,
  input  logic [63:0] head_bytes_lo,
  input  logic [63:0] head_bytes_mid,
  input  logic [63:0] head_bytes_hi,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  verdict,
  output logic [3:0]  stage_after
);

  localparam int IDX_W = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;

  logic                        in_accept;
  logic                        s1_adv;
  logic [9:0]                  red_idx;
  logic [IDX_W-1:0]            rd_idx;

  logic                        clear_busy;
  logic [IDX_W-1:0]            clear_addr;

  imfsc_pkg::stage_t           stage_mem [FLOW_COUNT];
  imfsc_pkg::stage_t           rd_data;

  logic                        s1_valid;
  logic [IDX_W-1:0]            s1_idx;
  logic                        s1_new;
  logic                        s1_tcp;
  logic [15:0]                 s1_len;
  logic [imfsc_pkg::HEAD_BITS-1:0] s1_head;

  logic                        last_wr_valid;
  logic [IDX_W-1:0]            last_wr_idx;
  imfsc_pkg::stage_t           last_wr_stage;

  imfsc_pkg::stage_t           stored;
  imfsc_pkg::stage_t           stage_next;
  imfsc_pkg::verdict_t         verdict_next;
  logic [7:0]                  b [imfsc_pkg::HEAD_BYTES];
  logic                        fixed_hdr;
  logic                        core_hit;
  logic                        arm_hit;
  logic                        len_tag;
  logic                        conf_ok;

  // flow index reduced modulo FLOW_COUNT
  always_comb begin
    red_idx = flow_index;
    for (int k = 9; k >= 0; k--) begin
      if ((FLOW_COUNT << k) <= 1023) begin
        if (red_idx >= 10'(FLOW_COUNT << k)) begin
          red_idx = red_idx - 10'(FLOW_COUNT << k);
        end
      end
    end
  end

  assign rd_idx    = IDX_W'(red_idx);
  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !clear_busy && (!s1_valid || s1_adv);
  assign in_accept = in_valid && in_ready;

  // clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clear_addr <= '0;
    end else if (clear_busy) begin
      if (clear_addr == IDX_W'(FLOW_COUNT - 1)) begin
        clear_busy <= 1'b0;
      end
      clear_addr <= clear_addr + 1'b1;
    end
  end

  // stage memory
  always_ff @(posedge clk) begin
    if (clear_busy) begin
      stage_mem[clear_addr] <= imfsc_pkg::STAGE_ZERO;
    end else if (s1_adv) begin
      stage_mem[s1_idx] <= stage_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_data <= stage_mem[rd_idx];
    end
  end

  // stage one registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_idx  <= rd_idx;
      s1_new  <= new_flow;
      s1_tcp  <= is_tcp;
      s1_len  <= pkt_len;
      s1_head <= {head_bytes_hi, head_bytes_mid, head_bytes_lo};
    end
  end

  // last write, forwarded to a read issued at the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      last_wr_valid <= 1'b0;
    end else if (s1_adv) begin
      last_wr_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      last_wr_idx   <= s1_idx;
      last_wr_stage <= stage_next;
    end
  end

  // signature matching
  always_comb begin
    for (int i = 0; i < imfsc_pkg::HEAD_BYTES; i++) begin
      b[i] = s1_head[8*i +: 8];
    end
  end

  always_comb begin
    fixed_hdr = (s1_len >= imfsc_pkg::LEN_HDR)
             && (b[0] == imfsc_pkg::HDR_B0) && (b[1] == imfsc_pkg::HDR_B1)
             && (b[2] == imfsc_pkg::BYTE_ZERO) && (b[3] == imfsc_pkg::BYTE_ZERO)
             && (b[5] == imfsc_pkg::BYTE_ZERO) && (b[6] == imfsc_pkg::BYTE_ZERO)
             && (b[16] == imfsc_pkg::HDR_B16)
             && (b[22] == imfsc_pkg::BYTE_ZERO) && (b[23] == imfsc_pkg::BYTE_ZERO);
    core_hit  = (s1_len >= imfsc_pkg::LEN_CORE)
             && ((s1_head[8*imfsc_pkg::CORE_OFF_A +: 8*imfsc_pkg::CORE_LEN]
                  == imfsc_pkg::MARKER_CORE)
              || (s1_head[8*imfsc_pkg::CORE_OFF_B +: 8*imfsc_pkg::CORE_LEN]
                  == imfsc_pkg::MARKER_CORE));
    arm_hit   = ((b[0] == imfsc_pkg::ARM_B0) && (b[3] == imfsc_pkg::BYTE_ONE))
             || ((b[2] == imfsc_pkg::ARM_B2) && (b[3] == imfsc_pkg::BYTE_ONE));
    len_tag   = (s1_len != 16'd0) && ({8'd0, b[0]} == (s1_len - 16'd1));
    conf_ok   = (len_tag && (b[3] == imfsc_pkg::BYTE_ZERO)
                 && (b[4] == imfsc_pkg::BYTE_ZERO)
                 && (s1_head[8*imfsc_pkg::HAND_OFF +: 8*imfsc_pkg::HAND_LEN]
                     == imfsc_pkg::MARKER_HAND))
             || (len_tag && (b[2][7:4] == imfsc_pkg::CONF_NIB)
                 && (b[3] == imfsc_pkg::BYTE_ONE) && (b[4] == imfsc_pkg::BYTE_ZERO));
  end

  // stage update
  always_comb begin
    if (s1_new) begin
      stored = imfsc_pkg::STAGE_ZERO;
    end else if (last_wr_valid && (last_wr_idx == s1_idx)) begin
      stored = last_wr_stage;
    end else begin
      stored = rd_data;
    end

    stage_next   = stored;
    verdict_next = imfsc_pkg::VERDICT_UNDECIDED;
    priority if (!s1_tcp) begin
      stage_next = stored;
    end else if (fixed_hdr || core_hit) begin
      verdict_next = imfsc_pkg::VERDICT_MATCH;
    end else if (arm_hit) begin
      stage_next = imfsc_pkg::STAGE_ARMED;
    end else begin
      if (stored == imfsc_pkg::STAGE_ARMED) begin
        stage_next = conf_ok ? imfsc_pkg::STAGE_CONF : imfsc_pkg::STAGE_BROKEN;
      end
      if (stage_next == imfsc_pkg::STAGE_CONF) begin
        verdict_next = imfsc_pkg::VERDICT_MATCH;
      end else begin
        if (stage_next != imfsc_pkg::STAGE_MAX) begin
          stage_next = stage_next + 4'd1;
        end
        if (stage_next > imfsc_pkg::STAGE_LIMIT) begin
          verdict_next = imfsc_pkg::VERDICT_EXCLUDED;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      verdict     <= verdict_next;
      stage_after <= stage_next;
    end
  end

`ifndef SYNTHESIS
  a_no_beat_while_clearing : assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> !in_ready)
    else $error("input beat taken during clearing pass");

  a_accept_fills_s1 : assert property (@(posedge clk) disable iff (rst)
    in_accept |=> s1_valid)
    else $error("accepted beat not held in stage one");

  a_excluded_stage : assert property (@(posedge clk) disable iff (rst)
    out_valid && (verdict == imfsc_pkg::VERDICT_EXCLUDED)
      |-> (stage_after > imfsc_pkg::STAGE_LIMIT))
    else $error("excluded verdict with low stage");

  a_verdict_code : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (verdict != 2'd3))
    else $error("invalid verdict code");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: instant-messaging flow classifier testbench
// Drives packet beats into the classifier and predicts each verdict and the
// stage written back for the flow, using a private copy of the stage table.
// Directed packets cover the signatures, the handshake, zero length, the
// exclusion limit and non-TCP traffic; random traffic is mostly well-formed
// handshake and signature sequences over a small set of reused flows, with
// noise, broken handshakes, random idling on both sides and a long receiver
// hold-off that stalls the input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [79:0] CORE_TAG      = 80'h40_65_72_6f_43_6d_63_54_07_40;
  localparam logic [39:0] HANDSHAKE_TAG = 40'h40_78_77_02_40;

  typedef struct {
    logic [9:0]   flow;
    logic         newf;
    logic         tcp;
    logic [15:0]  len;
    logic [191:0] head;
  } pkt_t;

  typedef struct {
    imfsc_pkg::verdict_t verdict;
    imfsc_pkg::stage_t   stage;
    logic [9:0]          flow;
  } flow_outcome_t;

  logic        clk;
  logic        rst            = 1'b1;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [9:0]  flow_index     = '0;
  logic        new_flow       = 1'b0;
  logic        is_tcp         = 1'b0;
  logic [15:0] pkt_len        = '0;
  logic [63:0] head_bytes_lo  = '0;
  logic [63:0] head_bytes_mid = '0;
  logic [63:0] head_bytes_hi  = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [1:0]  verdict;
  logic [3:0]  stage_after;

  imfsc_pkg::stage_t flow_stage [1024];
  flow_outcome_t     pending_verdicts [$];
  int                mismatches  = 0;
  int                beats_sent  = 0;
  bit                tx_calm     = 1'b0;
  bit                rx_calm     = 1'b0;
  int                hold_starts = 0;
  int                hold_seen   = 0;
  int                hold_left   = 0;

  im_flow_signature_classifier dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .flow_index     (flow_index),
    .new_flow       (new_flow),
    .is_tcp         (is_tcp),
    .pkt_len        (pkt_len),
    .head_bytes_lo  (head_bytes_lo),
    .head_bytes_mid (head_bytes_mid),
    .head_bytes_hi  (head_bytes_hi),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .verdict        (verdict),
    .stage_after    (stage_after)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("im_flow_signature_classifier: mismatch");
    $finish;
  end

  function automatic flow_outcome_t classify_pkt(input pkt_t p);
    flow_outcome_t     r;
    logic [7:0]        b [24];
    imfsc_pkg::stage_t st;
    bit                fixed_hdr;
    bit                core;
    bit                len_tag;
    bit                ok;
    int                i;
    for (i = 0; i < 24; i++) b[i] = p.head[8*i +: 8];
    if (p.newf) flow_stage[p.flow] = imfsc_pkg::STAGE_ZERO;
    st = flow_stage[p.flow];
    r.verdict = imfsc_pkg::VERDICT_UNDECIDED;
    r.flow = p.flow;
    if (p.tcp) begin
      fixed_hdr = p.len >= 16'd24 && b[0] == 8'h88 && b[1] == 8'h06
        && b[2] == 8'h00 && b[3] == 8'h00 && b[5] == 8'h00 && b[6] == 8'h00
        && b[16] == 8'h01 && b[22] == 8'h00 && b[23] == 8'h00;
      core = p.len >= 16'd20
        && (p.head[56 +: 80] == CORE_TAG || p.head[72 +: 80] == CORE_TAG);
      len_tag = p.len >= 16'd1 && {8'h00, b[0]} == p.len - 16'd1;
      if (fixed_hdr || core) begin
        r.verdict = imfsc_pkg::VERDICT_MATCH;
      end else if ((b[0] == 8'h37 && b[3] == 8'h01) || (b[2] == 8'h0c && b[3] == 8'h01)) begin
        st = imfsc_pkg::STAGE_ARMED;
      end else begin
        if (st == imfsc_pkg::STAGE_ARMED) begin
          ok = (len_tag && b[3] == 8'h00 && b[4] == 8'h00
                && p.head[56 +: 40] == HANDSHAKE_TAG)
            || (len_tag && b[2][7:4] == 4'h2 && b[3] == 8'h01 && b[4] == 8'h00);
          st = ok ? imfsc_pkg::STAGE_CONF : imfsc_pkg::STAGE_BROKEN;
        end
        if (st == imfsc_pkg::STAGE_CONF) begin
          r.verdict = imfsc_pkg::VERDICT_MATCH;
        end else begin
          if (st < imfsc_pkg::STAGE_MAX) st = st + 4'd1;
          if (st > imfsc_pkg::STAGE_LIMIT) r.verdict = imfsc_pkg::VERDICT_EXCLUDED;
        end
      end
      flow_stage[p.flow] = st;
    end
    r.stage = st;
    return r;
  endfunction

  function automatic logic [191:0] rand_head();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic pkt_t make_pkt(input logic [9:0] fl, input logic nf, input logic tcp,
                                    input logic [15:0] len, input logic [191:0] head);
    pkt_t p;
    p.flow = fl;
    p.newf = nf;
    p.tcp  = tcp;
    p.len  = len;
    p.head = head;
    return p;
  endfunction

  // bytes past the payload length arrive as zero
  function automatic pkt_t trim_tail(input pkt_t p);
    int i;
    for (i = 0; i < 24; i++) if (i >= p.len) p.head[8*i +: 8] = 8'h00;
    return p;
  endfunction

  function automatic pkt_t gen_fixed(input logic [9:0] fl, input logic [15:0] len);
    pkt_t p;
    p = make_pkt(fl, 1'b0, 1'b1, len, rand_head());
    p.head[31:0]    = 32'h0000_0688;
    p.head[55:40]   = 16'h0000;
    p.head[135:128] = 8'h01;
    p.head[191:176] = 16'h0000;
    return p;
  endfunction

  function automatic pkt_t gen_core(input logic [9:0] fl, input int off, input logic [15:0] len);
    pkt_t p;
    p = make_pkt(fl, 1'b0, 1'b1, len, rand_head());
    p.head[8*off +: 80] = CORE_TAG;
    return p;
  endfunction

  function automatic pkt_t gen_arm(input logic [9:0] fl, input int variant);
    pkt_t p;
    p = make_pkt(fl, $urandom_range(99) < 20, 1'b1, 16'($urandom_range(0, 64)), rand_head());
    if (variant == 0) p.head[7:0] = 8'h37;
    else p.head[23:16] = 8'h0c;
    p.head[31:24] = 8'h01;
    return p;
  endfunction

  function automatic pkt_t gen_confirm(input logic [9:0] fl, input int variant,
                                       input logic [15:0] len);
    pkt_t p;
    p = make_pkt(fl, 1'b0, 1'b1, len, rand_head());
    p.head[7:0] = len[7:0] - 8'd1;
    if (variant == 0) begin
      p.head[39:24] = 16'h0000;
      p.head[56 +: 40] = HANDSHAKE_TAG;
    end else begin
      p.head[23:20] = 4'h2;
      p.head[39:24] = 16'h0001;
    end
    return p;
  endfunction

  function automatic pkt_t gen_noise(input logic [9:0] fl);
    pkt_t p;
    p = make_pkt(fl, $urandom_range(99) < 8, $urandom_range(99) < 90,
                 16'(($urandom_range(1) == 0) ? $urandom_range(0, 30) : $urandom),
                 rand_head());
    if ($urandom_range(1) == 0) p = trim_tail(p);
    return p;
  endfunction

  function automatic logic [9:0] pick_flow();
    int unsigned slot;
    slot = $urandom_range(0, 15);
    if ($urandom_range(99) < 25) return 10'($urandom);
    return slot[3] ? 10'd1016 + slot[2:0] : 10'(slot[2:0]);
  endfunction

  function automatic logic [15:0] pick_tag_len();
    if ($urandom_range(99) < 90) return 16'($urandom_range(1, 64));
    return 16'($urandom_range(65, 256));
  endfunction

  task automatic send_pkt(input pkt_t p);
    int gap;
    gap = 0;
    if (!tx_calm && $urandom_range(99) < 15) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    flow_index     <= p.flow;
    new_flow       <= p.newf;
    is_tcp         <= p.tcp;
    pkt_len        <= p.len;
    head_bytes_lo  <= p.head[63:0];
    head_bytes_mid <= p.head[127:64];
    head_bytes_hi  <= p.head[191:128];
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    pending_verdicts.push_back(classify_pkt(p));
    beats_sent++;
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_traffic(input int target);
    int         stop_at;
    int         pick;
    int         k;
    logic [9:0] fl;
    pkt_t       p;
    stop_at = beats_sent + target;
    while (beats_sent < stop_at) begin
      fl = pick_flow();
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_pkt(gen_arm(fl, $urandom_range(1)));
        p = gen_confirm(fl, $urandom_range(1), pick_tag_len());
        if ($urandom_range(3) == 0) p = trim_tail(p);
        send_pkt(p);
        repeat ($urandom_range(0, 2)) send_pkt(gen_noise(fl));
      end else if (pick < 42) begin
        send_pkt(gen_arm(fl, $urandom_range(1)));
        if ($urandom_range(1) == 0) begin
          p = gen_confirm(fl, $urandom_range(1), pick_tag_len());
          k = $urandom_range(0, 11);
          p.head[8*k +: 8] = p.head[8*k +: 8] ^ (8'h01 << $urandom_range(0, 7));
          send_pkt(p);
        end else begin
          send_pkt(gen_noise(fl));
        end
      end else if (pick < 56) begin
        if ($urandom_range(3) == 0) send_pkt(gen_fixed(fl, 16'($urandom_range(0, 23))));
        else if ($urandom_range(9) == 0)
          send_pkt(gen_fixed(fl, 16'($urandom_range(24, 65535))));
        else send_pkt(gen_fixed(fl, 16'($urandom_range(24, 128))));
      end else if (pick < 70) begin
        send_pkt(gen_core(fl, ($urandom_range(1) == 0) ? 7 : 9,
                          16'(($urandom_range(4) == 0) ? $urandom_range(0, 19)
                                                       : $urandom_range(20, 600))));
      end else if (pick < 80) begin
        p = gen_noise(fl);
        p.tcp = 1'b0;
        send_pkt(p);
      end else begin
        repeat ($urandom_range(1, 4)) send_pkt(gen_noise(fl));
      end
    end
  endtask

  task automatic test_directed();
    pkt_t p;
    send_pkt(make_pkt(10'd0, 1'b0, 1'b0, 16'hffff, '1));
    send_pkt(make_pkt(10'd1023, 1'b1, 1'b1, 16'd0, '0));
    // zero length never satisfies the length tag of the handshake
    send_pkt(gen_arm(10'd10, 0));
    p = gen_confirm(10'd10, 0, 16'd1);
    p.len = 16'd0;
    p.head[7:0] = 8'hff;
    send_pkt(p);
    send_pkt(gen_fixed(10'd2, 16'd24));
    send_pkt(gen_fixed(10'd2, 16'd23));
    send_pkt(gen_fixed(10'd2, 16'hffff));
    send_pkt(gen_core(10'd3, 7, 16'd20));
    send_pkt(gen_core(10'd3, 9, 16'hffff));
    send_pkt(gen_core(10'd3, 9, 16'd19));
    send_pkt(gen_arm(10'd4, 0));
    send_pkt(gen_confirm(10'd4, 0, 16'd12));
    send_pkt(make_pkt(10'd4, 1'b0, 1'b1, 16'd40, '0));
    send_pkt(gen_arm(10'd4, 1));
    send_pkt(gen_confirm(10'd4, 1, 16'd256));
    send_pkt(gen_arm(10'd6, 0));
    send_pkt(make_pkt(10'd6, 1'b0, 1'b1, 16'd40, '0));
    send_pkt(make_pkt(10'd6, 1'b1, 1'b0, 16'd1, rand_head()));
    repeat (4) send_pkt(make_pkt(10'd8, 1'b0, 1'b1, 16'd3, '0));
    send_pkt(make_pkt(10'd512, 1'b0, 1'b1, 16'h8000, '1));
    wait_results_drained();
  endtask

  task automatic test_mixed_traffic();
    run_traffic(600);
    wait_results_drained();
  endtask

  task automatic test_steady_stream();
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    run_traffic(80);
    wait_results_drained();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  task automatic test_backpressure();
    tx_calm = 1'b1;
    hold_starts++;
    run_traffic(50);
    wait_results_drained();
    tx_calm = 1'b0;
  endtask

  // receiver: random stalls, calm stretch and a long hold-off
  always @(posedge clk) begin
    if (hold_starts != hold_seen) begin
      hold_seen <= hold_starts;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 20);
    end
  end

  always @(posedge clk) begin : result_check
    flow_outcome_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t result beat with nothing expected: verdict %0d stage %0d",
                 $time, verdict, stage_after);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (verdict !== want.verdict) begin
          $display("%0t flow %0d verdict: expected %0d actual %0d",
                   $time, want.flow, want.verdict, verdict);
          mismatches++;
        end
        if (stage_after !== want.stage) begin
          $display("%0t flow %0d stage_after: expected %0d actual %0d",
                   $time, want.flow, want.stage, stage_after);
          mismatches++;
        end
      end
    end
  end

  initial begin
    foreach (flow_stage[i]) flow_stage[i] = imfsc_pkg::STAGE_ZERO;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_mixed_traffic();
    test_steady_stream();
    test_backpressure();
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("im_flow_signature_classifier: match");
    end else begin
      $display("im_flow_signature_classifier: mismatch");
    end
    $finish;
  end

endmodule
